/* rtl/core/cpcl_pkg.sv */
// Shared types, field layout and constants for the chassis power current limiter.
package cpcl_pkg;

    // Input item layout (s_tdata)
    localparam int LEVEL_W   = 4;
    localparam int VOLT_W    = 12;
    localparam int BUF_W     = 9;
    localparam int CMD_W     = 15;
    localparam int N_MOTORS  = 4;
    localparam int LEVEL_LSB = 0;
    localparam int VOLT_LSB  = LEVEL_LSB + LEVEL_W;
    localparam int BUF_LSB   = VOLT_LSB + VOLT_W;
    localparam int CMD_LSB   = BUF_LSB + BUF_W;
    localparam int S_DATA_W  = ((CMD_LSB + N_MOTORS * CMD_W + 7) / 8) * 8;
    localparam int S_USER_W  = 2;
    localparam int USER_CTRL = 0;
    localparam int USER_NREF = 1;

    // Result item layout (m_tdata)
    localparam int OUT_W     = 16;
    localparam int LIM_W     = 13;
    localparam int STAGE_W   = 3;
    localparam int LIMX_LSB  = N_MOTORS * OUT_W;
    localparam int LIMY_LSB  = LIMX_LSB + LIM_W;
    localparam int STAGE_LSB = LIMY_LSB + LIM_W;
    localparam int M_DATA_W  = ((STAGE_LSB + STAGE_W + 7) / 8) * 8;

    // Datapath widths
    localparam int T_W    = 31;  // b*(b+60)^2*stage numerator
    localparam int MB_W   = 32;  // second multiplier operand, wide enough for the reciprocal
    localparam int PROD_W = T_W + MB_W;
    localparam int N_W    = 45;  // |cmd| * T
    localparam int SF_W   = 4;   // stage numerator, 1..10
    localparam int Q_W    = 16;

    // Scaling: r = cmd * S * P / (10 * 864000), P = 864000 when buffer factor is 1
    localparam int              BUF_DEN    = 864000;
    localparam int              STAGE_DEN  = 10;
    localparam logic [N_W-1:0]  DIV_D      = N_W'(BUF_DEN * STAGE_DEN);
    localparam logic [N_W-1:0]  DIV_LIMIT  = DIV_D << Q_W;
    localparam logic [BUF_W:0]  BUF_OFFSET = (BUF_W + 1)'(60);
    localparam logic [BUF_W-1:0] BUF_LOW   = BUF_W'(60);
    localparam logic [BUF_W-1:0] BUF_HIGH  = BUF_W'(250);

    // Divide by DIV_D = 2^DIV_SH * DIV_ODD: drop the power of two, then multiply by
    // the rounded-up reciprocal of DIV_ODD; exact for every dividend below 2^T_W
    localparam int              DIV_SH     = 9;
    localparam int              DIV_ODD    = (BUF_DEN * STAGE_DEN) >> DIV_SH;
    localparam int              RECIP_SH   = 46;
    localparam logic [MB_W-1:0] RECIP_M    =
        MB_W'(((64'd1 << RECIP_SH) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));

    // Capacitor voltage thresholds (0.01 V)
    localparam logic [VOLT_W-1:0] V_HI       = VOLT_W'(2200);
    localparam logic [VOLT_W-1:0] V_MID      = VOLT_W'(1900);
    localparam logic [VOLT_W-1:0] V_LOW      = VOLT_W'(1700);
    localparam logic [VOLT_W-1:0] V_CLR_ONE  = VOLT_W'(2250);
    localparam logic [VOLT_W-1:0] V_CLR_TWO  = VOLT_W'(2050);
    localparam logic [VOLT_W-1:0] V_CLR_THR  = VOLT_W'(1800);

    // Stages
    localparam logic [STAGE_W-1:0] STAGE_1 = STAGE_W'(1);
    localparam logic [STAGE_W-1:0] STAGE_2 = STAGE_W'(2);
    localparam logic [STAGE_W-1:0] STAGE_3 = STAGE_W'(3);
    localparam logic [STAGE_W-1:0] STAGE_4 = STAGE_W'(4);

    localparam logic [SF_W-1:0] SF_STAGE_1 = SF_W'(1);
    localparam logic [SF_W-1:0] SF_STAGE_2 = SF_W'(2);
    localparam logic [SF_W-1:0] SF_STAGE_3 = SF_W'(5);
    localparam logic [SF_W-1:0] SF_STAGE_4 = SF_W'(7);
    localparam logic [SF_W-1:0] SF_UNITY   = SF_W'(STAGE_DEN);

    // Speed factor codes
    localparam logic [1:0] SPD_ZERO   = 2'd0;
    localparam logic [1:0] SPD_ONE    = 2'd1;
    localparam logic [1:0] SPD_TWO    = 2'd2;
    localparam logic [1:0] SPD_ONE_P4 = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_TWO   = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = LEVEL_W'(3);

    localparam int BASE_SPEED_X  = 2000;
    localparam int BASE_SPEED_Y  = 2000;
    localparam int CTRL_SPEED_MM = 1000;
    localparam logic [LIM_W-1:0] LIM_CTRL = LIM_W'(CTRL_SPEED_MM);
    localparam logic [LIM_W-1:0] LIMX_1   = LIM_W'(BASE_SPEED_X);
    localparam logic [LIM_W-1:0] LIMX_2   = LIM_W'(BASE_SPEED_X * 2);
    localparam logic [LIM_W-1:0] LIMX_14  = LIM_W'((BASE_SPEED_X * 14) / 10);
    localparam logic [LIM_W-1:0] LIMY_1   = LIM_W'(BASE_SPEED_Y);
    localparam logic [LIM_W-1:0] LIMY_2   = LIM_W'(BASE_SPEED_Y * 2);
    localparam logic [LIM_W-1:0] LIMY_14  = LIM_W'((BASE_SPEED_Y * 14) / 10);

    // Multiplier step codes
    localparam logic [3:0] MUL_SQ     = 4'd0;   // (b+60)^2
    localparam logic [3:0] MUL_BUF    = 4'd1;   // * b, or load 864000
    localparam logic [3:0] MUL_STAGE  = 4'd2;   // * stage numerator
    localparam logic [3:0] MUL_CMD0   = 4'd3;   // * |cmd_0| .. |cmd_3| in turn
    localparam logic [3:0] MUL_RECIP0 = 4'd7;   // quotient of lane 0 .. 3 in turn
    localparam logic [3:0] MUL_LAST   = 4'd10;

    typedef struct packed {
        logic       load;       // capture an input item, update stage state
        logic       mul_en;
        logic [3:0] mul_step;
        logic       out_load;   // move result into output register
    } cpcl_cmd_t;

endpackage

/* rtl/core/cpcl_ctrl.sv */
// Sequencer for the limiter: multiply steps and result hand-off.
module cpcl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cpcl_pkg::cpcl_cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DONE} state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.mul_step  = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.load = accept;
                if (accept) begin
                    state_next = S_MUL;
                    cnt_next   = 4'd0;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == cpcl_pkg::MUL_LAST) begin
                    state_next = S_DONE;
                    cnt_next   = 4'd0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_DONE: begin
                cmd.out_load = !m_tvalid_reg || m_tready;
                if (cmd.out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready ##1 !s_tready)
        else $error("input taken again while an item is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule

/* rtl/core/cpcl_datapath.sv */
// Stage state, shared multiplier, four result lanes and the output register.
module cpcl_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cpcl_pkg::cpcl_cmd_t                 cmd,
    input  logic [cpcl_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [cpcl_pkg::S_USER_W-1:0]       s_tuser,
    output logic [cpcl_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int NM = cpcl_pkg::N_MOTORS;

    // item fields
    logic [cpcl_pkg::LEVEL_W-1:0] level;
    logic [cpcl_pkg::VOLT_W-1:0]  volt;
    logic [cpcl_pkg::BUF_W-1:0]   buf_in;
    logic                         ctrl_held;
    logic                         no_referee;
    logic [cpcl_pkg::CMD_W-1:0]   cmd_in [NM];

    // persistent state
    logic [1:0]                   spd_code_reg, spd_code_next;
    logic [cpcl_pkg::STAGE_W-1:0] cur_stage_reg, cur_stage_next;
    logic [cpcl_pkg::STAGE_W-1:0] prev_stage_reg, prev_stage_next;
    logic                         flag_one_reg, flag_one_next;
    logic                         flag_two_reg, flag_two_next;
    logic                         flag_thr_reg, flag_thr_next;

    // per-item working registers
    logic [cpcl_pkg::BUF_W-1:0]   buf_reg;
    logic                         unity_reg;
    logic [cpcl_pkg::SF_W-1:0]    sfac_reg;
    logic [cpcl_pkg::CMD_W-1:0]   mag_reg [NM];
    logic                         neg_reg [NM];
    logic [cpcl_pkg::LIM_W-1:0]   limx_reg, limy_reg;
    logic [cpcl_pkg::T_W-1:0]     t_reg;
    logic [cpcl_pkg::N_W-1:0]     num_reg [NM];
    logic [cpcl_pkg::Q_W-1:0]     q_reg [NM];
    logic                         ovf_reg [NM];

    // output register
    logic [cpcl_pkg::OUT_W-1:0]   res_reg [NM];
    logic [cpcl_pkg::LIM_W-1:0]   olimx_reg, olimy_reg;
    logic [cpcl_pkg::STAGE_W-1:0] ostage_reg;

    logic [cpcl_pkg::STAGE_W-1:0] stage_sel;
    logic [cpcl_pkg::SF_W-1:0]    sfac_sel;
    logic [cpcl_pkg::LIM_W-1:0]   limx_sel, limy_sel;
    logic                         hi, mid, low, unity;
    logic [cpcl_pkg::BUF_W:0]     bplus;
    logic [cpcl_pkg::T_W-1:0]     mul_a;
    logic [cpcl_pkg::MB_W-1:0]    mul_b;
    logic [cpcl_pkg::PROD_W-1:0]  mul_p;
    logic [1:0]                   lane_idx;

    assign level      = s_tdata[cpcl_pkg::LEVEL_LSB +: cpcl_pkg::LEVEL_W];
    assign volt       = s_tdata[cpcl_pkg::VOLT_LSB +: cpcl_pkg::VOLT_W];
    assign buf_in     = s_tdata[cpcl_pkg::BUF_LSB +: cpcl_pkg::BUF_W];
    assign ctrl_held  = s_tuser[cpcl_pkg::USER_CTRL];
    assign no_referee = s_tuser[cpcl_pkg::USER_NREF];

    for (genvar g = 0; g < NM; g++) begin : g_cmd
        assign cmd_in[g] = s_tdata[cpcl_pkg::CMD_LSB + g * cpcl_pkg::CMD_W +: cpcl_pkg::CMD_W];
    end

    assign hi    = volt > cpcl_pkg::V_HI;
    assign mid   = (volt > cpcl_pkg::V_MID) && !hi;
    assign low   = (volt > cpcl_pkg::V_LOW) && (volt <= cpcl_pkg::V_MID);
    assign unity = no_referee || ((buf_in > cpcl_pkg::BUF_LOW) && (buf_in <= cpcl_pkg::BUF_HIGH));

    // stage choice with hysteresis, and the state it leaves
    always_comb begin
        if (hi && !flag_one_reg) begin
            stage_sel = cpcl_pkg::STAGE_1;
            sfac_sel  = cpcl_pkg::SF_STAGE_1;
        end else if ((hi && flag_one_reg) || (mid && !flag_two_reg)) begin
            stage_sel = cpcl_pkg::STAGE_2;
            sfac_sel  = cpcl_pkg::SF_STAGE_2;
        end else if ((mid && flag_two_reg) || (low && !flag_thr_reg)) begin
            stage_sel = cpcl_pkg::STAGE_3;
            sfac_sel  = cpcl_pkg::SF_STAGE_3;
        end else begin
            stage_sel = cpcl_pkg::STAGE_4;
            sfac_sel  = cpcl_pkg::SF_STAGE_4;
        end

        if (level <= cpcl_pkg::LEVEL_ONE) begin
            spd_code_next = cpcl_pkg::SPD_ONE;
        end else if (level == cpcl_pkg::LEVEL_TWO) begin
            spd_code_next = cpcl_pkg::SPD_TWO;
        end else if (level == cpcl_pkg::LEVEL_THREE) begin
            spd_code_next = cpcl_pkg::SPD_ONE_P4;
        end else begin
            spd_code_next = spd_code_reg;
        end

        case (spd_code_next)
            cpcl_pkg::SPD_ONE: begin
                limx_sel = cpcl_pkg::LIMX_1;
                limy_sel = cpcl_pkg::LIMY_1;
            end
            cpcl_pkg::SPD_TWO: begin
                limx_sel = cpcl_pkg::LIMX_2;
                limy_sel = cpcl_pkg::LIMY_2;
            end
            cpcl_pkg::SPD_ONE_P4: begin
                limx_sel = cpcl_pkg::LIMX_14;
                limy_sel = cpcl_pkg::LIMY_14;
            end
            default: begin
                limx_sel = '0;
                limy_sel = '0;
            end
        endcase

        cur_stage_next  = cur_stage_reg;
        prev_stage_next = prev_stage_reg;
        flag_one_next   = flag_one_reg;
        flag_two_next   = flag_two_reg;
        flag_thr_next   = flag_thr_reg;
        if (!ctrl_held) begin
            cur_stage_next  = stage_sel;
            prev_stage_next = stage_sel;
            if (volt > cpcl_pkg::V_CLR_ONE) begin
                flag_one_next = 1'b0;
            end else if (stage_sel == cpcl_pkg::STAGE_1 && prev_stage_reg == cpcl_pkg::STAGE_2) begin
                flag_one_next = 1'b1;
            end
            if (volt > cpcl_pkg::V_CLR_TWO) begin
                flag_two_next = 1'b0;
            end else if (stage_sel == cpcl_pkg::STAGE_2 && prev_stage_reg == cpcl_pkg::STAGE_3) begin
                flag_two_next = 1'b1;
            end
            if (volt > cpcl_pkg::V_CLR_THR) begin
                flag_thr_next = 1'b0;
            end else if (stage_sel == cpcl_pkg::STAGE_3 && prev_stage_reg == cpcl_pkg::STAGE_4) begin
                flag_thr_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_code_reg   <= cpcl_pkg::SPD_ZERO;
            cur_stage_reg  <= cpcl_pkg::STAGE_1;
            prev_stage_reg <= cpcl_pkg::STAGE_1;
            flag_one_reg   <= 1'b0;
            flag_two_reg   <= 1'b0;
            flag_thr_reg   <= 1'b0;
        end else if (cmd.load) begin
            spd_code_reg   <= spd_code_next;
            cur_stage_reg  <= cur_stage_next;
            prev_stage_reg <= prev_stage_next;
            flag_one_reg   <= flag_one_next;
            flag_two_reg   <= flag_two_next;
            flag_thr_reg   <= flag_thr_next;
        end
    end

    // capture of the item's operands
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            buf_reg   <= buf_in;
            unity_reg <= unity;
            sfac_reg  <= ctrl_held ? cpcl_pkg::SF_UNITY : sfac_sel;
            limx_reg  <= ctrl_held ? cpcl_pkg::LIM_CTRL : limx_sel;
            limy_reg  <= ctrl_held ? cpcl_pkg::LIM_CTRL : limy_sel;
            for (int i = 0; i < NM; i++) begin
                neg_reg[i] <= cmd_in[i][cpcl_pkg::CMD_W-1];
                mag_reg[i] <= cmd_in[i][cpcl_pkg::CMD_W-1] ? (~cmd_in[i] + 1'b1) : cmd_in[i];
            end
        end
    end

    // shared multiplier, one product per step
    assign bplus    = {1'b0, buf_reg} + cpcl_pkg::BUF_OFFSET;
    assign lane_idx = (cmd.mul_step >= cpcl_pkg::MUL_RECIP0) ?
                      2'(cmd.mul_step - cpcl_pkg::MUL_RECIP0) :
                      2'(cmd.mul_step - cpcl_pkg::MUL_CMD0);

    always_comb begin
        case (cmd.mul_step)
            cpcl_pkg::MUL_SQ: begin
                mul_a = cpcl_pkg::T_W'(bplus);
                mul_b = cpcl_pkg::MB_W'(bplus);
            end
            cpcl_pkg::MUL_BUF: begin
                mul_a = unity_reg ? cpcl_pkg::T_W'(cpcl_pkg::BUF_DEN) : t_reg;
                mul_b = unity_reg ? cpcl_pkg::MB_W'(1) : cpcl_pkg::MB_W'(buf_reg);
            end
            cpcl_pkg::MUL_STAGE: begin
                mul_a = t_reg;
                mul_b = cpcl_pkg::MB_W'(sfac_reg);
            end
            default: begin
                if (cmd.mul_step >= cpcl_pkg::MUL_RECIP0) begin
                    // below the overflow limit the shifted numerator fits in T_W bits
                    mul_a = num_reg[lane_idx][cpcl_pkg::DIV_SH +: cpcl_pkg::T_W];
                    mul_b = cpcl_pkg::RECIP_M;
                end else begin
                    mul_a = t_reg;
                    mul_b = cpcl_pkg::MB_W'(mag_reg[lane_idx]);
                end
            end
        endcase
    end

    assign mul_p = cpcl_pkg::PROD_W'(mul_a) * cpcl_pkg::PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            if (cmd.mul_step < cpcl_pkg::MUL_CMD0) begin
                t_reg <= mul_p[cpcl_pkg::T_W-1:0];
            end else if (cmd.mul_step < cpcl_pkg::MUL_RECIP0) begin
                num_reg[lane_idx] <= mul_p[cpcl_pkg::N_W-1:0];
            end else begin
                q_reg[lane_idx]   <= mul_p[cpcl_pkg::RECIP_SH +: cpcl_pkg::Q_W];
                ovf_reg[lane_idx] <= num_reg[lane_idx] >= cpcl_pkg::DIV_LIMIT;
            end
        end
    end

    function automatic logic [cpcl_pkg::OUT_W-1:0] saturate(
        input logic [cpcl_pkg::Q_W-1:0] q,
        input logic                     neg,
        input logic                     ovf
    );
        logic [cpcl_pkg::OUT_W-1:0] pos_max;
        logic [cpcl_pkg::OUT_W-1:0] neg_min;
        pos_max = {1'b0, {(cpcl_pkg::OUT_W-1){1'b1}}};
        neg_min = {1'b1, {(cpcl_pkg::OUT_W-1){1'b0}}};
        if (neg) begin
            return (ovf || q > neg_min) ? neg_min : (~q + 1'b1);
        end
        return (ovf || q[cpcl_pkg::Q_W-1]) ? pos_max : q;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            for (int i = 0; i < NM; i++) begin
                res_reg[i] <= saturate(q_reg[i], neg_reg[i], ovf_reg[i]);
            end
            olimx_reg  <= limx_reg;
            olimy_reg  <= limy_reg;
            ostage_reg <= cur_stage_reg;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < NM; i++) begin
            m_tdata[i * cpcl_pkg::OUT_W +: cpcl_pkg::OUT_W] = res_reg[i];
        end
        m_tdata[cpcl_pkg::LIMX_LSB +: cpcl_pkg::LIM_W]    = olimx_reg;
        m_tdata[cpcl_pkg::LIMY_LSB +: cpcl_pkg::LIM_W]    = olimy_reg;
        m_tdata[cpcl_pkg::STAGE_LSB +: cpcl_pkg::STAGE_W] = ostage_reg;
    end

    a_ctrl_keeps_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && ctrl_held) |=> $stable(cur_stage_reg) && $stable(prev_stage_reg))
        else $error("stage changed while ctrl held");

    a_flag_one_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && !ctrl_held && volt > cpcl_pkg::V_CLR_ONE) |=> !flag_one_reg)
        else $error("hold flag one not cleared at high voltage");

    a_prev_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.load) |-> prev_stage_reg == cur_stage_reg)
        else $error("previous stage out of step with current stage");

endmodule

/* rtl/core/chassis_power_current_limiter_core.sv */
// Top level of the chassis power current limiter: controller plus datapath.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: level, cap voltage, buffer, cmd 0..3;
//          |     |                    | s_tuser: ctrl_held, no_referee
//  m_      | out | m_tvalid/m_tready  | m_tdata: scaled cmd 0..3, limit x, limit y, stage
//
// An item passes from acceptance through 11 steps of the one shared 31x32 multiplier
// (square, buffer, stage, four currents, four reciprocal divides), then the output load.
// s_tready is high only while no item is in work; it returns as soon as the result sits
// in the output register, so a new item is not taken before the last one is through.
// If m_tready is held low, the following item stops before its output load.
// Reset (aresetn low, synchronous) sets stage 1, clears the hold flags and the
// speed factor, and empties the output register.
module chassis_power_current_limiter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // level[3:0], cap_voltage[15:4], buffer_energy[24:16], motor_cmd_0[39:25],
    // motor_cmd_1[54:40], motor_cmd_2[69:55], motor_cmd_3[84:70], zero fill
    input  logic [cpcl_pkg::S_DATA_W-1:0]      s_tdata,
    // ctrl_held[0], no_referee[1]
    input  logic [cpcl_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scaled_cmd_0[15:0], scaled_cmd_1[31:16], scaled_cmd_2[47:32], scaled_cmd_3[63:48],
    // speed_limit_x[76:64], speed_limit_y[89:77], stage[92:90], zero fill
    output logic [cpcl_pkg::M_DATA_W-1:0]      m_tdata
);

    cpcl_pkg::cpcl_cmd_t cmd;

    cpcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cpcl_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for chassis_power_current_limiter_core: random control ticks, scoreboard.
module tb;
    import cpcl_pkg::*;

    localparam int N_RANDOM    = 1250;
    localparam int QUIET_TAIL  = 150;     // last ticks are sent and taken with no idling
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0]                 level;
        logic                               ctrl;
        logic [VOLT_W-1:0]                  volt;
        logic                               nref;
        logic [BUF_W-1:0]                   buffer_j;
        logic [N_MOTORS-1:0][CMD_W-1:0]     cmd;
    } tick_t;

    typedef struct packed {
        logic [N_MOTORS-1:0][OUT_W-1:0]     scaled;
        logic [LIM_W-1:0]                   lim_x;
        logic [LIM_W-1:0]                   lim_y;
        logic [STAGE_W-1:0]                 stage;
    } limits_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [S_USER_W-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;

    tick_t   tick_q[$];
    limits_t limits_q[$];
    tick_t   cur_tick;
    int      errors = 0;
    int      cycles = 0;
    int      tx_gap = 0;
    int      tx_calm = 0;
    int      rx_gap = 0;
    int      rx_calm = 0;
    logic    rx_next;
    logic [S_DATA_W-1:0] tx_data;
    logic [S_USER_W-1:0] tx_user;

    // limiter state as the block should hold it
    logic [1:0]          speed_code;
    logic [STAGE_W-1:0]  cur_stage;
    logic [STAGE_W-1:0]  prev_stage;
    logic                hold_one, hold_two, hold_three;

    chassis_power_current_limiter_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic limits_t limit_tick(input tick_t t);
        limits_t r;
        longint  stage_num, buf_num, buf_den, bb, prod, q;
        logic    hi, mid, low;
        stage_num = longint'(SF_UNITY);
        buf_num   = 1;
        buf_den   = 1;

        if (t.level <= LEVEL_ONE)
            speed_code = SPD_ONE;
        else if (t.level == LEVEL_TWO)
            speed_code = SPD_TWO;
        else if (t.level == LEVEL_THREE)
            speed_code = SPD_ONE_P4;

        if (t.ctrl) begin
            r.lim_x = LIM_CTRL;
            r.lim_y = LIM_CTRL;
        end else begin
            hi  = t.volt > V_HI;
            mid = t.volt > V_MID && t.volt <= V_HI;
            low = t.volt > V_LOW && t.volt <= V_MID;
            if (hi && !hold_one) begin
                cur_stage = STAGE_1;
                stage_num = longint'(SF_STAGE_1);
            end else if ((hi && hold_one) || (mid && !hold_two)) begin
                cur_stage = STAGE_2;
                stage_num = longint'(SF_STAGE_2);
            end else if ((mid && hold_two) || (low && !hold_three)) begin
                cur_stage = STAGE_3;
                stage_num = longint'(SF_STAGE_3);
            end else begin
                cur_stage = STAGE_4;
                stage_num = longint'(SF_STAGE_4);
            end
            case (speed_code)
                SPD_ONE:    begin r.lim_x = LIMX_1;  r.lim_y = LIMY_1;  end
                SPD_TWO:    begin r.lim_x = LIMX_2;  r.lim_y = LIMY_2;  end
                SPD_ONE_P4: begin r.lim_x = LIMX_14; r.lim_y = LIMY_14; end
                default:    begin r.lim_x = '0;      r.lim_y = '0;      end
            endcase
            // set on the way up, cleared well clear of the threshold; clear wins
            if (cur_stage == STAGE_1 && prev_stage == STAGE_2) hold_one = 1'b1;
            if (t.volt > V_CLR_ONE) hold_one = 1'b0;
            if (cur_stage == STAGE_2 && prev_stage == STAGE_3) hold_two = 1'b1;
            if (t.volt > V_CLR_TWO) hold_two = 1'b0;
            if (cur_stage == STAGE_3 && prev_stage == STAGE_4) hold_three = 1'b1;
            if (t.volt > V_CLR_THR) hold_three = 1'b0;
            prev_stage = cur_stage;
        end

        if (!t.nref && !(t.buffer_j > BUF_LOW && t.buffer_j <= BUF_HIGH)) begin
            bb      = longint'(t.buffer_j) + longint'(BUF_OFFSET);
            buf_num = longint'(t.buffer_j) * bb * bb;
            buf_den = longint'(BUF_DEN);
        end

        for (int i = 0; i < N_MOTORS; i++) begin
            prod = longint'(signed'(t.cmd[i])) * stage_num * buf_num;
            q    = prod / (longint'(STAGE_DEN) * buf_den);   // truncates toward zero
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            r.scaled[i] = q[OUT_W-1:0];
        end
        r.stage = cur_stage;
        return r;
    endfunction

    task automatic add_tick(input int level, input bit ctrl, input int volt, input bit nref,
                            input int buffer_j, input int c0, input int c1, input int c2,
                            input int c3);
        tick_t t;
        t.level    = LEVEL_W'(level);
        t.ctrl     = ctrl;
        t.volt     = VOLT_W'(volt);
        t.nref     = nref;
        t.buffer_j = BUF_W'(buffer_j);
        t.cmd[0]   = CMD_W'(c0);
        t.cmd[1]   = CMD_W'(c1);
        t.cmd[2]   = CMD_W'(c2);
        t.cmd[3]   = CMD_W'(c3);
        tick_q.push_back(t);
    endtask

    task automatic check_field(input string name, input logic signed [OUT_W:0] want,
                               input logic signed [OUT_W:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                limits_q.push_back(limit_tick(cur_tick));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    // the gap counts only once the block is ready for the next item
                    if (s_tready) tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    cur_tick = tick_q.pop_front();
                    tx_data  = '0;
                    tx_data[LEVEL_LSB +: LEVEL_W] = cur_tick.level;
                    tx_data[VOLT_LSB +: VOLT_W]   = cur_tick.volt;
                    tx_data[BUF_LSB +: BUF_W]     = cur_tick.buffer_j;
                    for (int i = 0; i < N_MOTORS; i++)
                        tx_data[CMD_LSB + i * CMD_W +: CMD_W] = cur_tick.cmd[i];
                    tx_user = '0;
                    tx_user[USER_CTRL] = cur_tick.ctrl;
                    tx_user[USER_NREF] = cur_tick.nref;
                    s_tdata  <= tx_data;
                    s_tuser  <= tx_user;
                    s_tvalid <= 1'b1;
                    if (tx_calm > 0)
                        tx_calm--;
                    else if (tick_q.size() >= QUIET_TAIL && $urandom_range(0, 2) == 0)
                        tx_gap = $urandom_range(1, 11);
                    else if ($urandom_range(0, 9) == 0)
                        tx_calm = $urandom_range(10, 40);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (limits_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    limits_t w;
                    w = limits_q.pop_front();
                    for (int i = 0; i < N_MOTORS; i++)
                        check_field($sformatf("scaled_cmd_%0d", i), signed'(w.scaled[i]),
                                    signed'(m_tdata[i * OUT_W +: OUT_W]));
                    check_field("speed_limit_x", {4'b0, w.lim_x}, {4'b0, m_tdata[LIMX_LSB +: LIM_W]});
                    check_field("speed_limit_y", {4'b0, w.lim_y}, {4'b0, m_tdata[LIMY_LSB +: LIM_W]});
                    check_field("stage", {14'b0, w.stage}, {14'b0, m_tdata[STAGE_LSB +: STAGE_W]});
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                rx_next = 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
                rx_next = 1'b1;
            end else if (tick_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                rx_gap  = $urandom_range(1, 11) - 1;
                rx_next = 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(20, 80);
                rx_next = 1'b1;
            end
            m_tready <= rx_next;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int     walk_v;
        int     lvl, bsel, bval;
        int     c[N_MOTORS];
        speed_code = SPD_ZERO;
        cur_stage  = STAGE_1;
        prev_stage = STAGE_1;
        hold_one   = 1'b0;
        hold_two   = 1'b0;
        hold_three = 1'b0;

        // unknown level straight from reset: speed limits stay at zero
        add_tick(15, 0, 2400, 1, 0, 16383, -16384, 0, -1);
        add_tick(0, 0, 4095, 0, 0, 16383, -16384, 1, -1);           // buffer empty: factor zero
        add_tick(1, 0, 2100, 0, 60, 16383, -16384, 12345, -777);    // stage 2, buffer at 60
        add_tick(2, 0, 2220, 0, 61, 16383, -16384, 100, -100);      // stage 1, hold flag one set
        add_tick(3, 0, 2230, 0, 250, 16383, -16384, 3, -3);         // held in stage 2
        add_tick(4, 0, 2300, 0, 251, 16383, -16384, 5000, -5000);   // flag one cleared
        add_tick(7, 0, 2300, 0, 511, 16383, -16384, 200, -200);     // big buffer, saturation
        add_tick(1, 0, 2000, 0, 300, 8000, -8000, 160, -170);
        add_tick(1, 0, 1800, 1, 300, 16383, -16384, 9, -9);         // stage 3
        add_tick(2, 0, 2000, 1, 0, 16383, -16384, 9, -9);           // back to 2, flag two set
        add_tick(2, 0, 2000, 1, 0, 16383, -16384, 9, -9);           // held in stage 3
        add_tick(3, 0, 1000, 0, 30, 16383, -16384, 9, -9);          // stage 4
        add_tick(3, 0, 1750, 0, 120, 16383, -16384, 9, -9);         // stage 3, flag three set
        add_tick(3, 0, 1750, 0, 120, 16383, -16384, 9, -9);         // held in stage 4
        add_tick(0, 1, 0, 0, 511, 16383, -16384, 40, -40);          // ctrl: stage kept, buffer on
        add_tick(9, 1, 4095, 1, 511, 16383, -16384, 40, -40);
        add_tick(1, 0, 1900, 0, 100, 1, -1, 11, -11);               // voltage boundaries
        add_tick(1, 0, 1901, 0, 100, 1, -1, 11, -11);
        add_tick(1, 0, 2200, 0, 100, 1, -1, 11, -11);
        add_tick(1, 0, 2201, 0, 100, 1, -1, 11, -11);
        add_tick(1, 0, 1700, 0, 100, 1, -1, 11, -11);
        add_tick(1, 0, 1701, 0, 100, 1, -1, 11, -11);
        add_tick(10, 0, 3200, 0, 1, 16383, -16384, 2, -2);
        add_tick(5, 0, 2251, 0, 400, 1234, -4321, 16383, -16384);

        // random ticks: the voltage mostly wanders around the stage thresholds
        walk_v = 2000;
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                walk_v = $urandom_range(0, 4095);
            end else begin
                walk_v = walk_v + int'($urandom_range(0, 100)) - 50;
                if (walk_v < 1500) walk_v = 1500;
                if (walk_v > 2500) walk_v = 2500;
            end
            lvl  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            bsel = $urandom_range(0, 2);
            case (bsel)
                0:       bval = $urandom_range(61, 250);
                1:       bval = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60)
                                                            : $urandom_range(251, 320);
                default: bval = $urandom_range(0, 511);
            endcase
            for (int i = 0; i < N_MOTORS; i++) begin
                if ($urandom_range(0, 9) == 0)
                    c[i] = ($urandom_range(0, 1) == 0) ? 16383 : -16384;
                else
                    c[i] = $urandom_range(0, 32767);
            end
            add_tick(lvl, $urandom_range(0, 7) == 0, walk_v, $urandom_range(0, 3) == 0, bval,
                     c[0], c[1], c[2], c[3]);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (tick_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (limits_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
